// File: hw/rtl/hsc_pkg.sv
// Shared types, register codes, state encodings and the color table of the hillshade colorizer.
// No dependencies; the shading unit and the top level refer to it by scoped names.
package hsc_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_WIDTH        = 3'd0,
      CSR_GRADIENT_SCALE   = 3'd1,
      CSR_ELEVATION_OFFSET = 3'd2,
      CSR_ELEVATION_SCALE  = 3'd3,
      CSR_NODATA_VALUE     = 3'd4,
      CSR_LIGHT_X          = 3'd5,
      CSR_LIGHT_Y          = 3'd6,
      CSR_LIGHT_Z          = 3'd7
   } hsc_csr_type;

   typedef struct packed {
      logic        [12:0] row_width;
      logic        [31:0] gradient_scale;
      logic signed [23:0] elevation_offset;
      logic        [23:0] elevation_scale;
      logic signed [23:0] nodata_value;
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
   } hsc_cfg_type;

   localparam hsc_cfg_type CFG_RESET = '{
      row_width:        13'd512,
      gradient_scale:   32'd8192,
      elevation_offset: 24'sd0,
      elevation_scale:  24'd65536,
      nodata_value:     24'sh800000,
      light_x:          16'shC000,
      light_y:          16'sh4000,
      light_z:          16'sd23170
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       opaque;
      logic       end_of_frame;
   } hsc_pixel_type;

   // Row phase: no row, one row, two or more rows complete
   localparam logic [1:0] PHASE_NONE = 2'd0;
   localparam logic [1:0] PHASE_ONE  = 2'd1;
   localparam logic [1:0] PHASE_TWO  = 2'd2;

   // Slope saturation limit, Q16.16
   localparam logic [30:0] SLOPE_LIM = 31'h7FFF_FFFF;
   localparam logic [16:0] SHADE_ONE = 17'd65536;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_UPDATE,
      CTL_SHADE
   } hsc_ctl_type;

   typedef enum logic [3:0] {
      SH_IDLE,
      SH_GRAD,
      SH_SCALE,
      SH_SAT,
      SH_PROD,
      SH_SUM,
      SH_SQRT,
      SH_DIVCHK,
      SH_DIV,
      SH_LEVEL,
      SH_COLOR,
      SH_DONE
   } hsc_shade_type;

   // Turbo color map, 256 entries of red, green, blue
   localparam logic [7:0] TURBO_ROM [256][3] = '{
'{48,18,59},'{50,21,67},'{51,24,74},'{52,27,81},'{53,30,88},'{54,33,95},'{55,36,102},'{56,39,109},
'{57,42,115},'{58,45,121},'{59,47,128},'{60,50,134},'{61,53,139},'{62,56,145},'{63,59,151},
'{63,62,156},
'{64,64,162},'{65,67,167},'{65,70,172},'{66,73,177},'{66,75,181},'{67,78,186},'{68,81,191},
'{68,84,195},
'{68,86,199},'{69,89,203},'{69,92,207},'{69,94,211},'{70,97,214},'{70,100,218},'{70,102,221},
'{70,105,224},
'{70,107,227},'{71,110,230},'{71,113,233},'{71,115,235},'{71,118,238},'{71,120,240},
'{71,123,242},'{70,125,244},
'{70,128,246},'{70,130,248},'{70,133,250},'{70,135,251},'{69,138,252},'{69,140,253},
'{68,143,254},'{67,145,254},
'{66,148,255},'{65,150,255},'{64,153,255},'{62,155,254},'{61,158,254},'{59,160,253},
'{58,163,252},'{56,165,251},
'{55,168,250},'{53,171,248},'{51,173,247},'{49,175,245},'{47,178,244},'{46,180,242},
'{44,183,240},'{42,185,238},
'{40,188,235},'{39,190,233},'{37,192,231},'{35,195,228},'{34,197,226},'{32,199,223},
'{31,201,221},'{30,203,218},
'{28,205,216},'{27,208,213},'{26,210,210},'{26,212,208},'{25,213,205},'{24,215,202},
'{24,217,200},'{24,219,197},
'{24,221,194},'{24,222,192},'{24,224,189},'{25,226,187},'{25,227,185},'{26,228,182},
'{28,230,180},'{29,231,178},
'{31,233,175},'{32,234,172},'{34,235,170},'{37,236,167},'{39,238,164},'{42,239,161},
'{44,240,158},'{47,241,155},
'{50,242,152},'{53,243,148},'{56,244,145},'{60,245,142},'{63,246,138},'{67,247,135},
'{70,248,132},'{74,248,128},
'{78,249,125},'{82,250,122},'{85,250,118},'{89,251,115},'{93,252,111},'{97,252,108},
'{101,253,105},'{105,253,102},
'{109,254,98},'{113,254,95},'{117,254,92},'{121,254,89},'{125,255,86},'{128,255,83},
'{132,255,81},'{136,255,78},
'{139,255,75},'{143,255,73},'{146,255,71},'{150,254,68},'{153,254,66},'{156,254,64},
'{159,253,63},'{161,253,61},
'{164,252,60},'{167,252,58},'{169,251,57},'{172,251,56},'{175,250,55},'{177,249,54},
'{180,248,54},'{183,247,53},
'{185,246,53},'{188,245,52},'{190,244,52},'{193,243,52},'{195,241,52},'{198,240,52},
'{200,239,52},'{203,237,52},
'{205,236,52},'{208,234,52},'{210,233,53},'{212,231,53},'{215,229,53},'{217,228,54},
'{219,226,54},'{221,224,55},
'{223,223,55},'{225,221,55},'{227,219,56},'{229,217,56},'{231,215,57},'{233,213,57},
'{235,211,57},'{236,209,58},
'{238,207,58},'{239,205,58},'{241,203,58},'{242,201,58},'{244,199,58},'{245,197,58},
'{246,195,58},'{247,193,58},
'{248,190,57},'{249,188,57},'{250,186,57},'{251,184,56},'{251,182,55},'{252,179,54},
'{252,177,54},'{253,174,53},
'{253,172,52},'{254,169,51},'{254,167,50},'{254,164,49},'{254,161,48},'{254,158,47},
'{254,155,45},'{254,153,44},
'{254,150,43},'{254,147,42},'{254,144,41},'{253,141,39},'{253,138,38},'{252,135,37},
'{252,132,35},'{251,129,34},
'{251,126,33},'{250,123,31},'{249,120,30},'{249,117,29},'{248,114,28},'{247,111,26},
'{246,108,25},'{245,105,24},
'{244,102,23},'{243,99,21},'{242,96,20},'{241,93,19},'{240,91,18},'{239,88,17},
'{237,85,16},'{236,83,15},
'{235,80,14},'{234,78,13},'{232,75,12},'{231,73,12},'{229,71,11},'{228,69,10},
'{226,67,10},'{225,65,9},
'{223,63,8},'{221,61,8},'{220,59,7},'{218,57,7},'{216,55,6},'{214,53,6},'{212,51,5},
'{210,49,5},
'{208,47,5},'{206,45,4},'{204,43,4},'{202,42,4},'{200,40,3},'{197,38,3},'{195,37,3},
'{193,35,2},
'{190,33,2},'{188,32,2},'{185,30,2},'{183,29,2},'{180,27,1},'{178,26,1},'{175,24,1},
'{172,23,1},
'{169,22,1},'{167,20,1},'{164,19,1},'{161,18,1},'{158,16,1},'{155,15,1},'{152,14,1},
'{149,13,1},
'{146,11,1},'{142,10,1},'{139,9,2},'{136,8,2},'{133,7,2},'{129,6,2},'{126,5,2},'{122,4,3}
   };

endpackage

// File: hw/rtl/hsc_if.sv
// Valid/ready channel interfaces for elevation samples and shaded pixels.
// Standalone; the top level and the testbench use them.
interface hsc_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [SAMPLE_BITS-1:0] elevation;
   logic                          first_of_frame;

   modport source (output valid, output mode, output elevation, output first_of_frame,
                   input ready);
   modport sink   (input valid, input mode, input elevation, input first_of_frame,
                   output ready);
endinterface

interface hsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       opaque;
   logic       end_of_frame;

   modport source (output valid, output red, output green, output blue, output opaque,
                   output end_of_frame, input ready);
   modport sink   (input valid, input red, input green, input blue, input opaque,
                   input end_of_frame, output ready);
endinterface

// File: hw/rtl/hsc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module hsc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/hsc_shade.sv
// Per-pixel shading unit: Sobel gradients, slope scaling, iterative square root and
// division for the Lambertian term, then color lookup and modulation. Uses hsc_pkg.
module hsc_shade #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] job_win [9],
   input  logic                          job_eof,
   input  hsc_pkg::hsc_cfg_type          cfg,
   output logic                          res_valid,
   input  logic                          res_ack,
   output hsc_pkg::hsc_pixel_type        res
);

   localparam int GW = SAMPLE_BITS + 3;
   localparam int DW = ((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24) + 1;
   localparam int MW = GW + 16;
   localparam int PW = GW + 32;
   localparam int IW = DW - 1 + 24;

   hsc_pkg::hsc_shade_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] v_ff [9];
   logic                          eof_ff;
   logic                          nodata_ff;
   logic                          gx_neg_ff, gy_neg_ff;
   logic        [GW-1:0]          magx_ff, magy_ff;
   logic                          idx_pos_ff;
   logic        [DW-2:0]          udiff_ff;
   logic        [MW-1:0]          pxlo_ff, pxhi_ff, pylo_ff, pyhi_ff;
   logic        [IW-1:0]          iprod_ff;
   logic        [30:0]            pmx_ff, pmy_ff;
   logic        [7:0]             idx_ff;
   logic        [61:0]            sqx_ff, sqy_ff;
   logic signed [47:0]            nx_ff, ny_ff;
   logic        [63:0]            d2_ff;
   logic signed [49:0]            n_ff;
   logic        [63:0]            rem_ff, root_ff, bit_ff;
   logic        [4:0]             cnt_ff;
   logic        [49:0]            drem_ff, dv_ff;
   logic        [16:0]            q_ff, s_ff;
   logic        [7:0]             h_ff;
   logic        [7:0]             t_ff [3];
   hsc_pkg::hsc_pixel_type        res_ff;

   // Combinational terms of the individual steps
   logic signed [GW-1:0]  gx, gy;
   logic signed [DW-1:0]  diff;
   logic        [PW-1:0]  px_full, py_full;
   logic        [IW:0]    iround;
   logic        [IW-16:0] ishift;
   logic signed [31:0]    psx, psy;
   logic        [63:0]    trial;
   logic        [49:0]    num, dv17;
   logic        [16:0]    q_next;
   logic        [27:0]    level;
   logic        [15:0]    cprod [3];
   logic        [16:0]    cdiv [3];

   always_comb begin
      gx = (GW'(v_ff[6]) + (GW'(v_ff[7]) <<< 1) + GW'(v_ff[8]))
         - (GW'(v_ff[0]) + (GW'(v_ff[1]) <<< 1) + GW'(v_ff[2]));
      gy = (GW'(v_ff[2]) + (GW'(v_ff[5]) <<< 1) + GW'(v_ff[8]))
         - (GW'(v_ff[0]) + (GW'(v_ff[3]) <<< 1) + GW'(v_ff[6]));
      diff = DW'(v_ff[4]) - DW'(cfg.elevation_offset);
      px_full = PW'(pxlo_ff) + (PW'(pxhi_ff) << 16);
      py_full = PW'(pylo_ff) + (PW'(pyhi_ff) << 16);
      iround = (IW + 1)'(iprod_ff) + (IW + 1)'(32768);
      ishift = iround[IW:16];
      psx = gx_neg_ff ? -$signed({1'b0, pmx_ff}) : $signed({1'b0, pmx_ff});
      psy = gy_neg_ff ? -$signed({1'b0, pmy_ff}) : $signed({1'b0, pmy_ff});
      trial = root_ff + bit_ff;
      num = {n_ff[48:0], 1'b0};
      dv17 = {root_ff[32:0], 17'd0};
      q_next = {q_ff[15:0], (drem_ff >= dv_ff)};
      level = 28'd51 * (28'd196608 + 28'd17 * 28'(s_ff)) + 28'd131072;
      for (int k = 0; k < 3; k++) begin
         cprod[k] = 16'(t_ff[k]) * 16'(h_ff) + 16'd127;
         cdiv[k]  = (17'(cprod[k]) + 17'(cprod[k] >> 8) + 17'd1) >> 8;
      end
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsc_pkg::SH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through the steps
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hsc_pkg::SH_IDLE:   if (start) state_in = hsc_pkg::SH_GRAD;
         hsc_pkg::SH_GRAD:   state_in = hsc_pkg::SH_SCALE;
         hsc_pkg::SH_SCALE:  state_in = hsc_pkg::SH_SAT;
         hsc_pkg::SH_SAT:    state_in = hsc_pkg::SH_PROD;
         hsc_pkg::SH_PROD:   state_in = hsc_pkg::SH_SUM;
         hsc_pkg::SH_SUM:    state_in = hsc_pkg::SH_SQRT;
         hsc_pkg::SH_SQRT:   if (cnt_ff == 5'd31) state_in = hsc_pkg::SH_DIVCHK;
         hsc_pkg::SH_DIVCHK: begin
            if (n_ff <= 0 || num >= dv17) state_in = hsc_pkg::SH_LEVEL;
            else state_in = hsc_pkg::SH_DIV;
         end
         hsc_pkg::SH_DIV:    if (cnt_ff == 5'd16) state_in = hsc_pkg::SH_LEVEL;
         hsc_pkg::SH_LEVEL:  state_in = hsc_pkg::SH_COLOR;
         hsc_pkg::SH_COLOR:  state_in = hsc_pkg::SH_DONE;
         hsc_pkg::SH_DONE:   if (res_ack) state_in = hsc_pkg::SH_IDLE;
         default:            state_in = hsc_pkg::SH_IDLE;
      endcase
   end

   // Datapath registers, one step per state
   always_ff @(posedge clock) begin
      case (state_ff)
         hsc_pkg::SH_IDLE: begin
            if (start) begin
               for (int k = 0; k < 9; k++) v_ff[k] <= job_win[k];
               eof_ff <= job_eof;
            end
         end
         hsc_pkg::SH_GRAD: begin
            gx_neg_ff  <= gx[GW-1];
            gy_neg_ff  <= gy[GW-1];
            magx_ff    <= gx[GW-1] ? GW'(-gx) : GW'(gx);
            magy_ff    <= gy[GW-1] ? GW'(-gy) : GW'(gy);
            nodata_ff  <= DW'(v_ff[4]) == DW'(cfg.nodata_value);
            idx_pos_ff <= diff > 0;
            udiff_ff   <= diff[DW-2:0];
         end
         hsc_pkg::SH_SCALE: begin
            pxlo_ff  <= MW'(magx_ff) * MW'(cfg.gradient_scale[15:0]);
            pxhi_ff  <= MW'(magx_ff) * MW'(cfg.gradient_scale[31:16]);
            pylo_ff  <= MW'(magy_ff) * MW'(cfg.gradient_scale[15:0]);
            pyhi_ff  <= MW'(magy_ff) * MW'(cfg.gradient_scale[31:16]);
            iprod_ff <= IW'(udiff_ff) * IW'(cfg.elevation_scale);
         end
         hsc_pkg::SH_SAT: begin
            pmx_ff <= (px_full > PW'(hsc_pkg::SLOPE_LIM)) ? hsc_pkg::SLOPE_LIM : px_full[30:0];
            pmy_ff <= (py_full > PW'(hsc_pkg::SLOPE_LIM)) ? hsc_pkg::SLOPE_LIM : py_full[30:0];
            if (!idx_pos_ff) idx_ff <= 8'd0;
            else if (ishift > (IW - 15)'(255)) idx_ff <= 8'd255;
            else idx_ff <= ishift[7:0];
         end
         hsc_pkg::SH_PROD: begin
            sqx_ff <= 62'(pmx_ff) * 62'(pmx_ff);
            sqy_ff <= 62'(pmy_ff) * 62'(pmy_ff);
            nx_ff  <= 48'(psx) * 48'(cfg.light_x);
            ny_ff  <= 48'(psy) * 48'(cfg.light_y);
         end
         hsc_pkg::SH_SUM: begin
            d2_ff   <= 64'(sqx_ff) + 64'(sqy_ff) + 64'h1_0000_0000;
            n_ff    <= -50'(nx_ff) - 50'(ny_ff) + (50'(cfg.light_z) <<< 16);
            root_ff <= 64'd0;
            bit_ff  <= 64'h4000_0000_0000_0000;
            cnt_ff  <= 5'd0;
         end
         hsc_pkg::SH_SQRT: begin
            // One result bit per cycle of the integer square root
            if (cnt_ff == 5'd0) begin
               if (d2_ff >= trial) begin
                  rem_ff  <= d2_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  rem_ff  <= d2_ff;
                  root_ff <= root_ff >> 1;
               end
            end else if (rem_ff >= trial) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
         end
         hsc_pkg::SH_DIVCHK: begin
            if (n_ff <= 0) s_ff <= 17'd0;
            else if (num >= dv17) s_ff <= hsc_pkg::SHADE_ONE;
            drem_ff <= num;
            dv_ff   <= {1'b0, root_ff[32:0], 16'd0};
            q_ff    <= 17'd0;
            cnt_ff  <= 5'd0;
         end
         hsc_pkg::SH_DIV: begin
            // Restoring division, one quotient bit per cycle
            if (drem_ff >= dv_ff) drem_ff <= drem_ff - dv_ff;
            dv_ff  <= dv_ff >> 1;
            q_ff   <= q_next;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               s_ff <= (q_next > hsc_pkg::SHADE_ONE) ? hsc_pkg::SHADE_ONE : q_next;
            end
         end
         hsc_pkg::SH_LEVEL: begin
            h_ff <= level[25:18];
            for (int k = 0; k < 3; k++) t_ff[k] <= hsc_pkg::TURBO_ROM[idx_ff][k];
         end
         hsc_pkg::SH_COLOR: begin
            res_ff.red          <= nodata_ff ? 8'd0 : cdiv[0][7:0];
            res_ff.green        <= nodata_ff ? 8'd0 : cdiv[1][7:0];
            res_ff.blue         <= nodata_ff ? 8'd0 : cdiv[2][7:0];
            res_ff.opaque       <= !nodata_ff;
            res_ff.end_of_frame <= eof_ff;
         end
         default: begin
         end
      endcase
   end

   assign res_valid = (state_ff == hsc_pkg::SH_DONE);
   assign res       = res_ff;

endmodule

// File: hw/rtl/dem_hillshade_colorizer.sv
// Hillshade colorizer for elevation rasters: takes samples in raster order, keeps two rows
// in line RAMs and returns one Turbo-colored, Lambert-shaded pixel per centre sample, one
// row plus one sample after that sample arrives; flush items drain the last row. Samples
// are taken one at a time: a sample that yields no pixel holds the block through the RAM
// read and then the read-modify-write of both line RAMs and the 3x3 window; one that yields
// a pixel also waits for the shading unit's 32-step square root and, unless the shade is
// zero or saturates, its 17-step division. A finished pixel sits in an output register, so
// the next sample can enter while it waits. No clearing pass runs after reset. Uses hsc_pkg,
// hsc_if, hsc_ram and hsc_shade.
module dem_hillshade_colorizer #(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   hsc_req_if.sink                            req_chan,
   hsc_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [hsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hsc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);

   hsc_pkg::hsc_cfg_type   cfg_ff;
   hsc_pkg::hsc_ctl_type   ctl_ff, ctl_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [1:0]             phase_ff, phase_in;
   logic [CW-1:0]          flush_ff, flush_in;
   logic signed [SAMPLE_BITS-1:0] win_ff [9];
   logic                   mode_ff;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [CW-1:0]          addr_ff, addr_in;
   logic [1:0]             ph_ff, ph_in;
   logic                   rsp_valid_ff;
   hsc_pkg::hsc_pixel_type rsp_pix_ff;

   logic                   accept, restart, flush_live, wrap;
   logic [CW-1:0]          eff_w, eff_w_m1, col_eff, c_sel, c_inc;
   logic [1:0]             ph_eff;
   logic [SAMPLE_BITS-1:0] up_rd, mid_rd;
   logic signed [SAMPLE_BITS-1:0] newcol [3];
   logic                   pre, post, upd_emit, final_emit, shade_start, ram_we;
   logic signed [SAMPLE_BITS-1:0] job_win [9];
   logic                   job_eof;
   logic                   shade_valid, out_free, shade_ack;
   hsc_pkg::hsc_pixel_type shade_pix;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= hsc_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (hsc_pkg::hsc_csr_type'(csr_index))
            hsc_pkg::CSR_ROW_WIDTH:        cfg_ff.row_width <= csr_wdata[12:0];
            hsc_pkg::CSR_GRADIENT_SCALE:   cfg_ff.gradient_scale <= csr_wdata;
            hsc_pkg::CSR_ELEVATION_OFFSET: cfg_ff.elevation_offset <= csr_wdata[23:0];
            hsc_pkg::CSR_ELEVATION_SCALE:  cfg_ff.elevation_scale <= csr_wdata[23:0];
            hsc_pkg::CSR_NODATA_VALUE:     cfg_ff.nodata_value <= csr_wdata[23:0];
            hsc_pkg::CSR_LIGHT_X:          cfg_ff.light_x <= csr_wdata[15:0];
            hsc_pkg::CSR_LIGHT_Y:          cfg_ff.light_y <= csr_wdata[15:0];
            hsc_pkg::CSR_LIGHT_Z:          cfg_ff.light_z <= csr_wdata[15:0];
         endcase
      end
   end

   // Clamp the row width into the supported range
   always_comb begin
      if (cfg_ff.row_width < 13'd2) eff_w = CW'(2);
      else if (32'(cfg_ff.row_width) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
      else eff_w = CW'(cfg_ff.row_width);
      eff_w_m1 = eff_w - CW'(1);
   end

   // Column selection for an incoming sample
   always_comb begin
      accept     = req_chan.valid && req_chan.ready;
      restart    = req_chan.first_of_frame || (flush_ff != '0);
      col_eff    = restart ? '0 : col_ff;
      ph_eff     = restart ? hsc_pkg::PHASE_NONE : phase_ff;
      c_sel      = (col_eff >= eff_w) ? eff_w_m1 : col_eff;
      c_inc      = c_sel + CW'(1);
      wrap       = c_inc >= eff_w;
      flush_live = (phase_ff != hsc_pkg::PHASE_NONE) && (col_ff == '0);
   end

   // Line RAMs: read at transfer, written back by samples in the cycle after. The next read cannot
   // start before that write lands, so no forwarding is needed.
   hsc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff[AW-1:0]),
      .wr_data (mid_rd),
      .rd_addr (req_chan.mode ? flush_ff[AW-1:0] : c_sel[AW-1:0]),
      .rd_data (up_rd)
   );

   hsc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff[AW-1:0]),
      .wr_data (x_ff),
      .rd_addr (req_chan.mode ? flush_ff[AW-1:0] : c_sel[AW-1:0]),
      .rd_data (mid_rd)
   );

   // New window column and pixel decisions of the update cycle
   always_comb begin
      if (mode_ff) begin
         newcol[0] = (ph_ff == hsc_pkg::PHASE_TWO) ? $signed(up_rd) : $signed(mid_rd);
         newcol[1] = $signed(mid_rd);
         newcol[2] = newcol[0];
         post      = addr_ff != '0;
      end else begin
         newcol[0] = (ph_ff == hsc_pkg::PHASE_ONE) ? $signed(x_ff) : $signed(up_rd);
         newcol[1] = $signed(mid_rd);
         newcol[2] = $signed(x_ff);
         post      = (ph_ff != hsc_pkg::PHASE_NONE) && (addr_ff != '0);
      end
      pre        = (addr_ff == '0) && (ph_ff == hsc_pkg::PHASE_TWO);
      upd_emit   = (ctl_ff == hsc_pkg::CTL_UPDATE) && (pre || post);
      ram_we     = (ctl_ff == hsc_pkg::CTL_UPDATE) && !mode_ff;
      final_emit = accept && req_chan.mode && flush_live && (flush_ff >= eff_w);
      shade_start = upd_emit || final_emit;
   end

   // Assemble the 3x3 job: the centre is always the newest complete column
   always_comb begin
      job_eof = final_emit;
      for (int r = 0; r < 3; r++) begin
         job_win[3 + r] = win_ff[6 + r];
         if (final_emit || pre) begin
            job_win[r]     = win_ff[3 + r];
            job_win[6 + r] = win_ff[3 + r];
         end else begin
            job_win[r]     = (addr_ff == CW'(1)) ? newcol[r] : win_ff[3 + r];
            job_win[6 + r] = newcol[r];
         end
      end
   end

   // Sequencer next state
   always_comb begin
      ctl_in   = ctl_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      flush_in = flush_ff;
      addr_in  = addr_ff;
      ph_in    = ph_ff;
      shade_ack = 1'b0;
      out_free = !rsp_valid_ff || rsp_chan.ready;
      unique case (ctl_ff)
         hsc_pkg::CTL_IDLE: begin
            if (accept && !req_chan.mode) begin
               col_in   = wrap ? '0 : c_inc;
               phase_in = (wrap && ph_eff != hsc_pkg::PHASE_TWO) ? ph_eff + 2'd1 : ph_eff;
               flush_in = '0;
               addr_in  = c_sel;
               ph_in    = ph_eff;
               ctl_in   = hsc_pkg::CTL_UPDATE;
            end else if (accept && flush_live) begin
               if (flush_ff < eff_w) begin
                  flush_in = flush_ff + CW'(1);
                  addr_in  = flush_ff;
                  ph_in    = phase_ff;
                  ctl_in   = hsc_pkg::CTL_UPDATE;
               end else begin
                  col_in   = '0;
                  phase_in = hsc_pkg::PHASE_NONE;
                  flush_in = '0;
                  ctl_in   = hsc_pkg::CTL_SHADE;
               end
            end
         end
         hsc_pkg::CTL_UPDATE: begin
            ctl_in = (pre || post) ? hsc_pkg::CTL_SHADE : hsc_pkg::CTL_IDLE;
         end
         hsc_pkg::CTL_SHADE: begin
            if (shade_valid && out_free) begin
               shade_ack = 1'b1;
               ctl_in    = hsc_pkg::CTL_IDLE;
            end
         end
         default: ctl_in = hsc_pkg::CTL_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= hsc_pkg::CTL_IDLE;
         col_ff   <= '0;
         phase_ff <= hsc_pkg::PHASE_NONE;
         flush_ff <= '0;
      end else begin
         ctl_ff   <= ctl_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         flush_ff <= flush_in;
      end
   end

   // Item registers and the 3x3 window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else if (ctl_ff == hsc_pkg::CTL_UPDATE && (mode_ff || ph_ff != hsc_pkg::PHASE_NONE))
      begin
         for (int k = 0; k < 6; k++) win_ff[k] <= win_ff[k + 3];
         for (int r = 0; r < 3; r++) win_ff[6 + r] <= newcol[r];
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      ph_ff   <= ph_in;
      if (accept) begin
         mode_ff <= req_chan.mode;
         x_ff    <= req_chan.elevation;
      end
   end

   hsc_shade #(.SAMPLE_BITS(SAMPLE_BITS)) u_shade (
      .clock     (clock),
      .reset     (reset),
      .start     (shade_start),
      .job_win   (job_win),
      .job_eof   (job_eof),
      .cfg       (cfg_ff),
      .res_valid (shade_valid),
      .res_ack   (shade_ack),
      .res       (shade_pix)
   );

   // Output register: load a finished pixel, drop it on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (shade_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (shade_ack) rsp_pix_ff <= shade_pix;
   end

   assign req_chan.ready        = (ctl_ff == hsc_pkg::CTL_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.red          = rsp_pix_ff.red;
   assign rsp_chan.green        = rsp_pix_ff.green;
   assign rsp_chan.blue         = rsp_pix_ff.blue;
   assign rsp_chan.opaque       = rsp_pix_ff.opaque;
   assign rsp_chan.end_of_frame = rsp_pix_ff.end_of_frame;

endmodule

// File: hw/rtl/hsc_checker.sv
// Port-level checks of the hillshade colorizer and the bind that attaches them.
// Depends on the top level dem_hillshade_colorizer.
module hsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_opaque,
   input logic       rsp_end_of_frame
);

   // Hold a stalled pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_opaque) && $stable(rsp_end_of_frame))
      else $error("pixel changed while stalled");

   // No pixel right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("pixel shown right after reset");

   // Nodata pixels are black
   a_nodata_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_opaque |-> rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0)
      else $error("transparent pixel is not black");

   // A sample transfer occupies the line RAM update cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode |=> !req_ready)
      else $error("sample accepted during line update");

endmodule

bind dem_hillshade_colorizer hsc_checker u_hsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_mode         (req_chan.mode),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_red          (rsp_chan.red),
   .rsp_green        (rsp_chan.green),
   .rsp_blue         (rsp_chan.blue),
   .rsp_opaque       (rsp_chan.opaque),
   .rsp_end_of_frame (rsp_chan.end_of_frame)
);

// File: dv/tb_dem_hillshade_colorizer.sv
// Testbench for dem_hillshade_colorizer: streams rasters and flushes, predicts every shaded
// pixel in-line and checks them in order. Depends on hsc_pkg, the channels in hsc_if and the top level.
`timescale 1ns / 1ps
module tb_dem_hillshade_colorizer;
   import hsc_pkg::*;

   localparam int ROW_MAX   = 4096;
   localparam int DRAIN_GAP = 100;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   hsc_req_if #(.SAMPLE_BITS(24)) req_chan ();
   hsc_rsp_if                     rsp_chan ();

   dem_hillshade_colorizer dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state
   hsc_cfg_type             shade_cfg;
   logic signed [23:0]      upper_line [ROW_MAX];
   logic signed [23:0]      middle_line [ROW_MAX];
   logic signed [23:0]      window [9];
   int                      col_pos;
   int                      rows_done;
   int                      drain_pos;
   hsc_pixel_type           pixel_queue [$];

   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int active_width();
      int w;
      w = shade_cfg.row_width;
      if (w < 2) w = 2;
      if (w > ROW_MAX) w = ROW_MAX;
      return w;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Sobel sum times gradient scale, saturated
   function automatic longint slope_of(longint g);
      longint unsigned mag, p;
      mag = (g < 0) ? longint'(-g) : longint'(g);
      p = mag * longint'(shade_cfg.gradient_scale);
      if (p > 64'd2147483647) p = 64'd2147483647;
      return (g < 0) ? -longint'(p) : longint'(p);
   endfunction

   // Shade and color the pixel centered on column cc of the window
   function automatic hsc_pixel_type shade_pixel(int lc, int cc, int rc, bit eof);
      hsc_pixel_type   px;
      longint          v [3][3];
      longint          gx, gy, p, q, n, diff;
      longint unsigned d, s, h, idx;
      for (int r = 0; r < 3; r++) begin
         v[r][0] = longint'(window[lc*3 + r]);
         v[r][1] = longint'(window[cc*3 + r]);
         v[r][2] = longint'(window[rc*3 + r]);
      end
      px = '0;
      px.end_of_frame = eof;
      if (v[1][1] == longint'($signed(shade_cfg.nodata_value))) return px;
      gx = (v[0][2] + 2*v[1][2] + v[2][2]) - (v[0][0] + 2*v[1][0] + v[2][0]);
      gy = (v[2][0] + 2*v[2][1] + v[2][2]) - (v[0][0] + 2*v[0][1] + v[0][2]);
      p = slope_of(gx);
      q = slope_of(gy);
      n = -(p * longint'($signed(shade_cfg.light_x))) - (q * longint'($signed(shade_cfg.light_y)))
          + longint'($signed(shade_cfg.light_z)) * 65536;
      d = int_sqrt(longint'(p*p) + longint'(q*q) + (64'd1 << 32));
      s = 0;
      if (n > 0) begin
         s = (2 * longint'(n)) / d;
         if (s > 65536) s = 65536;
      end
      h = (51 * (196608 + 17*s) + 131072) >> 18;
      diff = v[1][1] - longint'($signed(shade_cfg.elevation_offset));
      idx = 0;
      if (diff > 0) begin
         idx = (longint'(diff) * longint'(shade_cfg.elevation_scale) + 32768) >> 16;
         if (idx > 255) idx = 255;
      end
      px.red    = (longint'(TURBO_ROM[idx][0]) * h + 127) / 255;
      px.green  = (longint'(TURBO_ROM[idx][1]) * h + 127) / 255;
      px.blue   = (longint'(TURBO_ROM[idx][2]) * h + 127) / 255;
      px.opaque = 1'b1;
      return px;
   endfunction

   function automatic void shift_window(logic signed [23:0] top, logic signed [23:0] mid,
                                        logic signed [23:0] bot);
      for (int i = 0; i < 6; i++) window[i] = window[i+3];
      window[6] = top;
      window[7] = mid;
      window[8] = bot;
   endfunction

   // Advance the predictor by one accepted transfer
   function automatic void predict_item(bit mode, logic signed [23:0] x, bit first);
      int w, c, f;
      logic signed [23:0] up, mid, border;
      w = active_width();
      if (!mode) begin
         if (first || drain_pos != 0) begin
            col_pos = 0; rows_done = 0; drain_pos = 0;
         end
         c = col_pos;
         if (c >= w) c = w - 1;
         if (c == 0 && rows_done >= 2) pixel_queue.push_back(shade_pixel(1, 2, 1, 0));
         up  = upper_line[c];
         mid = middle_line[c];
         if (rows_done >= 1) begin
            shift_window(rows_done == 1 ? x : up, mid, x);
            if (c >= 1) pixel_queue.push_back(shade_pixel(c == 1 ? 2 : 0, 1, 2, 0));
         end
         upper_line[c]  = mid;
         middle_line[c] = x;
         if (c + 1 >= w) begin
            col_pos = 0;
            if (rows_done < 2) rows_done++;
         end else begin
            col_pos = c + 1;
         end
         return;
      end
      // Drop flushes with no complete row or in the middle of a row
      if (rows_done == 0 || col_pos != 0) return;
      f = drain_pos;
      if (f < w) begin
         if (f == 0 && rows_done >= 2) pixel_queue.push_back(shade_pixel(1, 2, 1, 0));
         mid    = middle_line[f];
         border = (rows_done >= 2) ? upper_line[f] : mid;
         shift_window(border, mid, border);
         if (f >= 1) pixel_queue.push_back(shade_pixel(f == 1 ? 2 : 0, 1, 2, 0));
         drain_pos = f + 1;
         return;
      end
      pixel_queue.push_back(shade_pixel(1, 2, 1, 1));
      rows_done = 0; col_pos = 0; drain_pos = 0;
   endfunction

   // Drive ready and check each pixel transfer
   always @(posedge clock) begin
      hsc_pixel_type got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.red, rsp_chan.green, rsp_chan.blue, rsp_chan.opaque,
                    rsp_chan.end_of_frame};
            if (pixel_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
            end else begin
               want = pixel_queue.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.opaque !== want.opaque ||
                   got.end_of_frame !== want.end_of_frame) begin
                  error_count++;
                  $display("%0t: pixel mismatch, expected r%0d g%0d b%0d o%0d e%0d, actual r%0d g%0d b%0d o%0d e%0d",
                           $time, want.red, want.green, want.blue, want.opaque,
                           want.end_of_frame, got.red, got.green, got.blue, got.opaque,
                           got.end_of_frame);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Send one item, idling first at random
   task automatic send_item(bit mode, logic signed [23:0] x, bit first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.mode           <= mode;
      req_chan.elevation      <= x;
      req_chan.first_of_frame <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_item(mode, x, first);
      items_sent++;
   endtask

   task automatic send_flushes(int count);
      for (int i = 0; i < count; i++) send_item(1'b1, $urandom, $urandom_range(1));
   endtask

   // Hold the input until every pixel has arrived and the block has settled
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_reg(hsc_csr_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ROW_WIDTH:        shade_cfg.row_width        = value[12:0];
         CSR_GRADIENT_SCALE:   shade_cfg.gradient_scale   = value;
         CSR_ELEVATION_OFFSET: shade_cfg.elevation_offset = value[23:0];
         CSR_ELEVATION_SCALE:  shade_cfg.elevation_scale  = value[23:0];
         CSR_NODATA_VALUE:     shade_cfg.nodata_value     = value[23:0];
         CSR_LIGHT_X:          shade_cfg.light_x          = value[15:0];
         CSR_LIGHT_Y:          shade_cfg.light_y          = value[15:0];
         default:              shade_cfg.light_z          = value[15:0];
      endcase
   endtask

   function automatic logic [15:0] pick_light();
      case ($urandom_range(4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return $urandom;
      endcase
   endfunction

   // Pick a new setting for every register, with extremes mixed in
   task automatic randomize_settings();
      case ($urandom_range(9))
         0:       write_reg(CSR_ROW_WIDTH, 0);
         1:       write_reg(CSR_ROW_WIDTH, 1);
         default: write_reg(CSR_ROW_WIDTH, $urandom_range(2, 10));
      endcase
      case ($urandom_range(5))
         0:       write_reg(CSR_GRADIENT_SCALE, 0);
         1:       write_reg(CSR_GRADIENT_SCALE, 32'hFFFF_FFFF);
         2:       write_reg(CSR_GRADIENT_SCALE, $urandom);
         default: write_reg(CSR_GRADIENT_SCALE, $urandom_range(0, 65536));
      endcase
      case ($urandom_range(4))
         0:       write_reg(CSR_ELEVATION_OFFSET, 32'h0080_0000);
         1:       write_reg(CSR_ELEVATION_OFFSET, 32'h007F_FFFF);
         default: write_reg(CSR_ELEVATION_OFFSET, $urandom_range(0, 4000) - 2000);
      endcase
      case ($urandom_range(5))
         0:       write_reg(CSR_ELEVATION_SCALE, 0);
         1:       write_reg(CSR_ELEVATION_SCALE, 32'h00FF_FFFF);
         2:       write_reg(CSR_ELEVATION_SCALE, $urandom);
         default: write_reg(CSR_ELEVATION_SCALE, $urandom_range(0, 1 << 18));
      endcase
      write_reg(CSR_NODATA_VALUE, ($urandom_range(1)) ? 32'h0080_0000 : $urandom);
      write_reg(CSR_LIGHT_X, pick_light());
      write_reg(CSR_LIGHT_Y, pick_light());
      write_reg(CSR_LIGHT_Z, pick_light());
   endtask

   function automatic logic signed [23:0] pick_elevation(int base);
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return shade_cfg.nodata_value;
      if (roll < 16) return $urandom;
      return base + $urandom_range(0, 64) - 32;
   endfunction

   // Directed: a 3x3 raster with extreme and nodata samples, saturated slopes
   task automatic test_small_raster();
      logic signed [23:0] samples [9] = '{24'sh7FFFFF, 24'sh800000, 0, -5, 100, 7, 1, 2, 3};
      write_reg(CSR_ROW_WIDTH, 3);
      write_reg(CSR_GRADIENT_SCALE, 32'hFFFF_FFFF);
      write_reg(CSR_ELEVATION_OFFSET, 32'hFFFF_FF00);
      write_reg(CSR_ELEVATION_SCALE, 32'h0002_0000);
      write_reg(CSR_NODATA_VALUE, 32'hFFFF_FFFB);
      write_reg(CSR_LIGHT_X, 16'h8000);
      write_reg(CSR_LIGHT_Y, 16'h7FFF);
      write_reg(CSR_LIGHT_Z, 16'h7FFF);
      for (int i = 0; i < 9; i++) send_item(1'b0, samples[i], i == 0);
      send_flushes(5);
      wait_idle();
   endtask

   // Directed: useless flushes, single-row raster, restarts, zero elevation scale
   task automatic test_frame_edges();
      write_reg(CSR_ROW_WIDTH, 2);
      write_reg(CSR_ELEVATION_SCALE, 0);
      send_flushes(1);
      send_item(1'b0, 10, 1'b1);
      send_flushes(1);
      send_item(1'b0, 20, 1'b0);
      send_flushes(3);
      send_item(1'b0, 30, 1'b1);
      send_item(1'b0, 40, 1'b0);
      send_item(1'b0, 50, 1'b1);
      send_item(1'b0, 60, 1'b0);
      send_item(1'b0, 70, 1'b0);
      send_item(1'b0, 80, 1'b0);
      send_flushes(1);
      send_item(1'b0, 90, 1'b0);
      wait_idle();
   endtask

   // Directed: row width shrinks mid-row, then the widest setting on a partial row
   task automatic test_width_change();
      write_reg(CSR_ROW_WIDTH, 4);
      write_reg(CSR_ELEVATION_SCALE, 32'h0001_0000);
      for (int i = 0; i < 7; i++) send_item(1'b0, i * 300, i == 0);
      wait_idle();
      write_reg(CSR_ROW_WIDTH, 2);
      for (int i = 0; i < 3; i++) send_item(1'b0, 5000 - i * 700, 1'b0);
      send_flushes(3);
      wait_idle();
      write_reg(CSR_ROW_WIDTH, 13'h1FFF);
      for (int i = 0; i < 6; i++) send_item(1'b0, $urandom, i == 0);
      send_item(1'b0, 1, 1'b1);
      wait_idle();
   endtask

   // Random rasters, mostly well-formed, some broken
   task automatic run_random_frame();
      int  w, rows, base, flushes;
      bit  broken;
      w      = active_width();
      rows   = $urandom_range(1, 4);
      base   = $urandom_range(0, 6000) - 3000;
      broken = ($urandom_range(99) < 15);
      for (int r = 0; r < rows; r++) begin
         for (int k = 0; k < w; k++) begin
            if (broken && $urandom_range(99) < 6) begin
               if ($urandom_range(1)) send_flushes(1);
               else send_item(1'b0, pick_elevation(base), 1'b1);
            end
            send_item(1'b0, pick_elevation(base), r == 0 && k == 0);
         end
      end
      flushes = w + 1 + $urandom_range(1);
      if (broken && $urandom_range(1)) begin
         send_flushes($urandom_range(1, w));
         send_item(1'b0, pick_elevation(base), 1'b0);
      end else begin
         send_flushes(flushes);
      end
   endtask

   task automatic test_random(int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) begin
         wait_idle();
         randomize_settings();
         run_random_frame();
         // Now and then, hold off until the block has delivered everything
         if ($urandom_range(9) == 0) wait_idle();
      end
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.mode  = 1'b0;
      req_chan.elevation      = '0;
      req_chan.first_of_frame = 1'b0;
      rsp_chan.ready = 1'b0;
      shade_cfg      = CFG_RESET;
      for (int i = 0; i < ROW_MAX; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      col_pos = 0; rows_done = 0; drain_pos = 0;
      error_count = 0; items_sent = 0;
      send_idle_pct = 37; recv_idle_pct = 55;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_raster();
      test_frame_edges();
      test_width_change();
      test_random(420);
      send_idle_pct = 55; recv_idle_pct = 37;
      test_random(420);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(420);

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
